FILE: rtl/address_symbol_range_lookup_top_macros.svh
// Assertion macros used by the checker file of the address range lookup block.
`ifndef ADDRESS_SYMBOL_RANGE_LOOKUP_TOP_MACROS_SVH
`define ADDRESS_SYMBOL_RANGE_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asrl assertion failed");

// Next-cycle implication, disabled during reset.
`define ASRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asrl assertion failed");

`endif

FILE: rtl/asrl_pkg.sv
// Shared types, constants and helper functions of the address range lookup block.
package asrl_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 64;
    localparam int KIND_W    = 3;
    localparam int CMD_W     = 3;
    localparam int RANK_W    = 3;
    localparam int MIDX_W    = 6;

    localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EXACT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTAIN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEAREST = 3'd4;

    localparam logic [KIND_W-1:0] KIND_IMAGE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEBUG  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXPORT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ENTRY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IMPORT = 3'd4;

    localparam logic [RANK_W-1:0] RANK_BEST   = 3'd0;
    localparam logic [RANK_W-1:0] RANK_EXPORT = 3'd1;
    localparam logic [RANK_W-1:0] RANK_ENTRY  = 3'd2;
    localparam logic [RANK_W-1:0] RANK_IMPORT = 3'd3;
    localparam logic [RANK_W-1:0] RANK_OTHER  = 3'd4;

    typedef struct packed {
        logic             vld;
        logic [CMD_W-1:0] cmd;
        logic             have;
        logic             status;
        logic             ins_has;
    } ctl_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] floor_addr;
        logic [ADDR_W:0]   ins_end;
        logic [ADDR_W-1:0] bstart;
        logic [SIZE_W-1:0] blen;
        logic [KIND_W-1:0] bkind;
    } tok_t;

    function automatic logic [RANK_W-1:0] kind_rank(input logic [KIND_W-1:0] kind);
        logic [RANK_W-1:0] r;
        case (kind)
            KIND_IMAGE:  r = RANK_BEST;
            KIND_DEBUG:  r = RANK_BEST;
            KIND_EXPORT: r = RANK_EXPORT;
            KIND_ENTRY:  r = RANK_ENTRY;
            KIND_IMPORT: r = RANK_IMPORT;
            default:     r = RANK_OTHER;
        endcase
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] norm_len(input logic [SIZE_W-1:0] len);
        return (len == '0) ? SIZE_ONE : len;
    endfunction

endpackage

FILE: rtl/asrl_ifs.sv
// Request and response channel interfaces of the address range lookup block.
interface asrl_req_if;
    import asrl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic              has_address;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] record_size;
    logic [KIND_W-1:0] record_kind;
    logic [ADDR_W-1:0] reach_limit;

    modport source (output valid, cmd, has_address, address, record_size, record_kind,
                    reach_limit, input ready);
    modport sink (input valid, cmd, has_address, address, record_size, record_kind,
                  reach_limit, output ready);
endinterface

interface asrl_rsp_if;
    import asrl_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic              status;
    logic [MIDX_W-1:0] match_index;
    logic [ADDR_W-1:0] match_address;
    logic [SIZE_W-1:0] match_size;
    logic [KIND_W-1:0] match_kind;

    modport source (output valid, found, status, match_index, match_address, match_size,
                    match_kind, input ready);
    modport sink (input valid, found, status, match_index, match_address, match_size,
                  match_kind, output ready);
endinterface

FILE: rtl/asrl_cell.sv
// One table cell: holds one record and updates the passing item's running best.
module asrl_cell #(
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  asrl_pkg::ctl_t      ctl_in,
    input  asrl_pkg::tok_t      tok_in,
    input  logic [IDX_W-1:0]    idx_in,
    input  logic [CNT_W-1:0]    cnt_in,
    output asrl_pkg::ctl_t      ctl_out,
    output asrl_pkg::tok_t      tok_out,
    output logic [IDX_W-1:0]    idx_out,
    output logic [CNT_W-1:0]    cnt_out
);
    import asrl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

    logic              ent_has_reg;
    logic [ADDR_W-1:0] ent_start_reg;
    logic [SIZE_W-1:0] ent_len_reg;
    logic [KIND_W-1:0] ent_kind_reg;
    logic [ADDR_W:0]   ent_end_reg;

    ctl_t              ctl_reg, ctl_next;
    tok_t              tok_reg, tok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg;

    logic              wr_en;
    logic              active;
    logic [RANK_W-1:0] ent_rank, best_rank;
    logic [SIZE_W-1:0] ent_nlen, best_nlen;
    logic              beats;
    logic              exact_hit, cover_hit, near_hit, near_better;
    logic              take;

    assign wr_en = ctl_in.vld && (ctl_in.cmd == CMD_INSERT) && !ctl_in.status
                   && (idx_in == MY_IDX);
    assign active = ctl_in.vld && (MY_CNT < cnt_in);

    assign ent_rank  = kind_rank(ent_kind_reg);
    assign best_rank = kind_rank(tok_in.bkind);
    assign ent_nlen  = norm_len(ent_len_reg);
    assign best_nlen = norm_len(tok_in.blen);
    assign beats = (ent_rank < best_rank) || ((ent_rank == best_rank) && (ent_nlen < best_nlen));

    assign exact_hit = ent_has_reg && (ent_start_reg == tok_in.addr);
    assign cover_hit = ent_has_reg &&
                       (ent_end_reg[ADDR_W] ? (tok_in.addr == ent_start_reg)
                                            : ((tok_in.addr >= ent_start_reg) &&
                                               ({1'b0, tok_in.addr} < ent_end_reg)));
    assign near_hit = ent_has_reg && (ent_start_reg <= tok_in.addr)
                      && (ent_start_reg >= tok_in.floor_addr);
    assign near_better = (ent_start_reg > tok_in.bstart)
                         || ((ent_start_reg == tok_in.bstart) && beats);

    always_comb
    begin
        case (ctl_in.cmd)
            CMD_EXACT:   take = exact_hit && !ctl_in.have;
            CMD_CONTAIN: take = cover_hit && (!ctl_in.have || beats);
            CMD_NEAREST: take = near_hit && (!ctl_in.have || near_better);
            default:     take = 1'b0;
        endcase
        take = take && active;

        ctl_next = ctl_in;
        tok_next = tok_in;
        idx_next = idx_in;
        if (take)
        begin
            ctl_next.have = 1'b1;
            idx_next      = MY_IDX;
            tok_next.bstart = ent_start_reg;
            tok_next.blen   = ent_len_reg;
            tok_next.bkind  = ent_kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_has_reg   <= ctl_in.ins_has;
            ent_start_reg <= tok_in.bstart;
            ent_len_reg   <= tok_in.blen;
            ent_kind_reg  <= tok_in.bkind;
            ent_end_reg   <= tok_in.ins_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_in;
    end

    assign ctl_out = ctl_reg;
    assign tok_out = tok_reg;
    assign idx_out = idx_reg;
    assign cnt_out = cnt_reg;
endmodule

FILE: rtl/address_symbol_range_lookup_top.sv
// Top level of the address range lookup block: intake, cell chain and result stage.
//
//   channel | role   | handshake     | payload
//   req     | sink   | valid / ready | cmd, has_address, address, record_size,
//           |        |               | record_kind, reach_limit
//   rsp     | source | valid / ready | found, status, match_index, match_address,
//           |        |               | match_size, match_kind
//
// Each item passes an intake register, TABLE_DEPTH cells, a park and an output register;
// a new item is taken only after the last result has moved from the park register into
// the output register, so only one item is in flight at a time.
// Reset empties the table (count to zero); stored records need no clearing.
// A stalled response holds in the output register while the next item is taken;
// its result then waits in the park register until the output frees.
module address_symbol_range_lookup_top #(
    parameter int TABLE_DEPTH = asrl_pkg::DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    asrl_req_if.sink  req,
    asrl_rsp_if.source rsp
);
    import asrl_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDXX_W = (IDX_W > MIDX_W) ? IDX_W : MIDX_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    ctl_t             ctl0_reg, ctl0_next;
    tok_t             tok0_reg, tok0_next;
    logic [IDX_W-1:0] idx0_reg, idx0_next;
    logic [CNT_W-1:0] cnt0_reg;

    ctl_t             ctl_w [TABLE_DEPTH+1];
    tok_t             tok_w [TABLE_DEPTH+1];
    logic [IDX_W-1:0] idx_w [TABLE_DEPTH+1];
    logic [CNT_W-1:0] cnt_w [TABLE_DEPTH+1];

    logic             park_vld_reg, park_vld_next;
    ctl_t             park_ctl_reg;
    tok_t             park_tok_reg;
    logic [IDX_W-1:0] park_idx_reg;
    logic             out_vld_reg, out_vld_next;
    ctl_t             out_ctl_reg;
    tok_t             out_tok_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [IDXX_W-1:0] out_idx_ext;

    logic acc, is_ins, full, ins_ok, out_free, park_move;

    assign req.ready = !busy_reg;
    assign acc       = req.valid && !busy_reg;
    assign is_ins    = (req.cmd == CMD_INSERT);
    assign full      = (count_reg >= DEPTH_CNT);
    assign ins_ok    = is_ins && !full;
    assign out_free  = !out_vld_reg || rsp.ready;
    assign park_move = park_vld_reg && out_free;

    always_comb
    begin
        count_next = count_reg;
        if (acc && (req.cmd == CMD_CLEAR))
        begin
            count_next = '0;
        end
        else if (acc && ins_ok)
        begin
            count_next = count_reg + CNT_ONE;
        end

        busy_next = busy_reg;
        if (acc)
        begin
            busy_next = 1'b1;
        end
        else if (park_move)
        begin
            busy_next = 1'b0;
        end

        ctl0_next         = '0;
        ctl0_next.vld     = acc;
        ctl0_next.cmd     = req.cmd;
        ctl0_next.status  = is_ins && full;
        ctl0_next.ins_has = req.has_address;

        tok0_next.addr       = req.address;
        tok0_next.floor_addr = (req.address >= req.reach_limit)
                               ? (req.address - req.reach_limit) : '0;
        tok0_next.ins_end    = {1'b0, req.address} + {1'b0, norm_len(req.record_size)};
        tok0_next.bstart     = ins_ok ? req.address : '0;
        tok0_next.blen       = ins_ok ? req.record_size : '0;
        tok0_next.bkind      = ins_ok ? req.record_kind : '0;
        idx0_next            = ins_ok ? count_reg[IDX_W-1:0] : '0;

        park_vld_next = park_vld_reg;
        if (ctl_w[TABLE_DEPTH].vld)
        begin
            park_vld_next = 1'b1;
        end
        else if (park_move)
        begin
            park_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (park_move)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            ctl0_reg     <= '0;
            park_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            count_reg    <= count_next;
            ctl0_reg     <= ctl0_next;
            park_vld_reg <= park_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            tok0_reg <= tok0_next;
            idx0_reg <= idx0_next;
            cnt0_reg <= count_reg;
        end
        if (ctl_w[TABLE_DEPTH].vld)
        begin
            park_ctl_reg <= ctl_w[TABLE_DEPTH];
            park_tok_reg <= tok_w[TABLE_DEPTH];
            park_idx_reg <= idx_w[TABLE_DEPTH];
        end
        if (park_move)
        begin
            out_ctl_reg <= park_ctl_reg;
            out_tok_reg <= park_tok_reg;
            out_idx_reg <= park_idx_reg;
        end
    end

    assign ctl_w[0] = ctl0_reg;
    assign tok_w[0] = tok0_reg;
    assign idx_w[0] = idx0_reg;
    assign cnt_w[0] = cnt0_reg;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        asrl_cell #(
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_w[g]),
            .tok_in  (tok_w[g]),
            .idx_in  (idx_w[g]),
            .cnt_in  (cnt_w[g]),
            .ctl_out (ctl_w[g+1]),
            .tok_out (tok_w[g+1]),
            .idx_out (idx_w[g+1]),
            .cnt_out (cnt_w[g+1])
        );
    end

    assign out_idx_ext = IDXX_W'(out_idx_reg);

    assign rsp.valid         = out_vld_reg;
    assign rsp.found         = out_ctl_reg.have;
    assign rsp.status        = out_ctl_reg.status;
    assign rsp.match_index   = out_idx_ext[MIDX_W-1:0];
    assign rsp.match_address = out_tok_reg.bstart;
    assign rsp.match_size    = out_tok_reg.blen;
    assign rsp.match_kind    = out_tok_reg.bkind;
endmodule

FILE: rtl/asrl_chk.sv
// Port-level checker of the address range lookup block and its bind.
`include "address_symbol_range_lookup_top_macros.svh"

module asrl_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_found,
    input logic                        rsp_status,
    input logic [asrl_pkg::MIDX_W-1:0] rsp_match_index,
    input logic [asrl_pkg::ADDR_W-1:0] rsp_match_address,
    input logic [asrl_pkg::SIZE_W-1:0] rsp_match_size,
    input logic [asrl_pkg::KIND_W-1:0] rsp_match_kind
);
    import asrl_pkg::*;

    `ASRL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASRL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_found) && $stable(rsp_status) &&
        $stable(rsp_match_address) && $stable(rsp_match_index))
    `ASRL_ASSERT_NOW(a_found_xor_full, clk, rst_n, rsp_valid, !(rsp_found && rsp_status))
    `ASRL_ASSERT_NOW(a_full_zero, clk, rst_n, rsp_valid && rsp_status,
        rsp_match_index == '0 && rsp_match_address == '0 &&
        rsp_match_size == '0 && rsp_match_kind == '0)
endmodule

bind address_symbol_range_lookup_top asrl_chk u_asrl_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_found         (rsp.found),
    .rsp_status        (rsp.status),
    .rsp_match_index   (rsp.match_index),
    .rsp_match_address (rsp.match_address),
    .rsp_match_size    (rsp.match_size),
    .rsp_match_kind    (rsp.match_kind)
);
